// ===== hw/rtl/atr_pkg.sv =====
`default_nettype none
package atr_pkg;

  // table geometry
  localparam int MAX_TILES = 64;
  localparam int IDX_W     = $clog2(MAX_TILES);
  localparam int CNT_W     = $clog2(MAX_TILES + 1);

  // field widths
  localparam int COORD_W = 13;
  localparam int SIZE_W  = COORD_W + 1;
  localparam int EDGE_W  = COORD_W + 2;
  localparam int CFG_AW  = 2;
  localparam int CFG_DW  = SIZE_W;

  // block-compressed alignment: low two bits must be clear
  localparam logic [1:0] ALIGN_MASK = 2'b11;

  // register reset values
  localparam logic [SIZE_W-1:0] ATLAS_DIM_RST = SIZE_W'(1024);

  // configuration register indexes
  typedef enum logic [CFG_AW-1:0] {
    CFG_ATLAS_WIDTH  = 2'd0,
    CFG_ATLAS_HEIGHT = 2'd1,
    CFG_BLOCK_ALIGN  = 2'd2,
    CFG_UNUSED       = 2'd3
  } cfg_idx_t;

  // request opcodes
  typedef enum logic [1:0] {
    OP_ALLOC = 2'd0,
    OP_FREE  = 2'd1,
    OP_CLEAR = 2'd2,
    OP_NOP   = 2'd3
  } op_t;

  // result status codes
  typedef enum logic [2:0] {
    STS_OK        = 3'd0,
    STS_EMPTY     = 3'd1,
    STS_MISALIGN  = 3'd2,
    STS_BOUNDS    = 3'd3,
    STS_OVERLAP   = 3'd4,
    STS_BADINDEX  = 3'd5,
    STS_FULL      = 3'd6
  } status_t;

  // controller states
  typedef enum logic [2:0] {
    S_IDLE,
    S_EVAL,
    S_SCAN,
    S_SHIFT,
    S_FIN
  } state_t;

  // one stored tile
  typedef struct packed {
    logic [COORD_W-1:0] left;
    logic [COORD_W-1:0] top;
    logic [SIZE_W-1:0]  width;
    logic [SIZE_W-1:0]  height;
  } entry_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic walk_init;
    logic walk_scan;
    logic walk_shift;
    logic finish;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic go_scan;
    logic go_shift;
    logic walk_done;
    logic out_free;
  } sts_t;

endpackage
`default_nettype wire

// ===== hw/rtl/atr_ctrl.sv =====
`default_nettype none
module atr_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_tvalid,
  output logic               in_tready,
  input  wire atr_pkg::sts_t sts,
  output atr_pkg::cmd_t      cmd
);

  atr_pkg::state_t state_r, state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= atr_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    case (state_r)
      atr_pkg::S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = atr_pkg::S_EVAL;
        end
      end
      atr_pkg::S_EVAL: begin
        cmd.walk_init = 1'b1;
        if (sts.go_scan) begin
          state_nxt = atr_pkg::S_SCAN;
        end else if (sts.go_shift) begin
          state_nxt = atr_pkg::S_SHIFT;
        end else begin
          state_nxt = atr_pkg::S_FIN;
        end
      end
      atr_pkg::S_SCAN: begin
        cmd.walk_scan = 1'b1;
        if (sts.walk_done) begin
          state_nxt = atr_pkg::S_FIN;
        end
      end
      atr_pkg::S_SHIFT: begin
        cmd.walk_shift = 1'b1;
        if (sts.walk_done) begin
          state_nxt = atr_pkg::S_FIN;
        end
      end
      atr_pkg::S_FIN: begin
        if (sts.out_free) begin
          cmd.finish = 1'b1;
          state_nxt  = atr_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = atr_pkg::S_IDLE;
      end
    endcase
  end

  // commands only ever come one at a time
  a_cmd_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(cmd))
    else $error("more than one datapath command");

  // a walk only ever follows an evaluation or itself
  a_walk_entry: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(state_r == atr_pkg::S_SCAN || state_r == atr_pkg::S_SHIFT)
      |-> $past(state_r) == atr_pkg::S_EVAL)
    else $error("walk entered without evaluation");

  // a finished request always goes back to idle
  a_fin_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |=> state_r == atr_pkg::S_IDLE)
    else $error("finish did not return to idle");

endmodule
`default_nettype wire

// ===== hw/rtl/atr_dp.sv =====
`default_nettype none
module atr_dp (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire atr_pkg::cmd_t                cmd,
  output atr_pkg::sts_t                     sts,
  input  wire logic [63:0]                  in_tdata,
  input  wire logic [atr_pkg::SIZE_W-1:0]   atlas_w,
  input  wire logic [atr_pkg::SIZE_W-1:0]   atlas_h,
  input  wire logic                         blk_align,
  output logic                              out_tvalid,
  input  wire logic                         out_tready,
  output logic [15:0]                       out_tdata
);

  localparam int CW = atr_pkg::COORD_W;
  localparam int SW = atr_pkg::SIZE_W;
  localparam int EW = atr_pkg::EDGE_W;
  localparam int NW = atr_pkg::CNT_W;
  localparam int AW = atr_pkg::IDX_W;

  // request registers
  atr_pkg::op_t  op_r;
  logic [CW-1:0] left_r, top_r;
  logic [SW-1:0] wid_r, hgt_r;
  logic [NW-1:0] idx_r;
  logic [EW-1:0] right_r, bot_r;

  // table state
  atr_pkg::entry_t mem [atr_pkg::MAX_TILES];
  atr_pkg::entry_t rd_data_r, wr_data;
  logic [NW-1:0]   cnt_r, cnt_nxt;
  logic [NW-1:0]   ptr_r;
  logic [AW-1:0]   rd_addr_r, wr_addr;
  logic            rd_en, rd_vld_r, wr_en, hit_r, ovl, append;

  // output register
  logic               out_vld_r;
  atr_pkg::status_t   res_st_r, res_st;
  logic [AW-1:0]      res_idx_r, res_idx;
  logic [NW-1:0]      res_cnt_r;

  // pre-check results
  atr_pkg::status_t pre_st;
  logic             empty, misal, oob, idx_ok;
  logic [EW-1:0]    t_right, t_bot;

  // capture the request
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r    <= atr_pkg::op_t'(in_tdata[1:0]);
      left_r  <= in_tdata[14:2];
      top_r   <= in_tdata[27:15];
      wid_r   <= in_tdata[41:28];
      hgt_r   <= in_tdata[55:42];
      idx_r   <= in_tdata[62:56];
      right_r <= EW'(in_tdata[14:2]) + EW'(in_tdata[41:28]);
      bot_r   <= EW'(in_tdata[27:15]) + EW'(in_tdata[55:42]);
    end
  end

  // size, alignment and bounds checks in order
  always_comb begin
    empty  = (wid_r == '0) || (hgt_r == '0);
    misal  = blk_align &&
             (((left_r[1:0] | top_r[1:0] | wid_r[1:0] | hgt_r[1:0])
               & atr_pkg::ALIGN_MASK) != 2'b00);
    oob    = (right_r > EW'(atlas_w)) || (bot_r > EW'(atlas_h));
    idx_ok = idx_r < cnt_r;
    if (empty) begin
      pre_st = atr_pkg::STS_EMPTY;
    end else if (misal) begin
      pre_st = atr_pkg::STS_MISALIGN;
    end else if (oob) begin
      pre_st = atr_pkg::STS_BOUNDS;
    end else begin
      pre_st = atr_pkg::STS_OK;
    end
  end

  // overlap of the entry just read against the request
  always_comb begin
    t_right = EW'(rd_data_r.left) + EW'(rd_data_r.width);
    t_bot   = EW'(rd_data_r.top) + EW'(rd_data_r.height);
    ovl = !((EW'(rd_data_r.left) >= right_r) || (t_right <= EW'(left_r)) ||
            (EW'(rd_data_r.top) >= bot_r) || (t_bot <= EW'(top_r)));
  end

  // walk pointer: scan from entry 0, compaction from the entry after the freed one
  assign rd_en = (cmd.walk_scan || cmd.walk_shift) && (ptr_r < cnt_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ptr_r    <= '0;
      rd_vld_r <= 1'b0;
      hit_r    <= 1'b0;
    end else begin
      if (cmd.walk_init) begin
        ptr_r    <= (op_r == atr_pkg::OP_FREE) ? idx_r + NW'(1) : '0;
        rd_vld_r <= 1'b0;
        hit_r    <= 1'b0;
      end else begin
        rd_vld_r <= rd_en;
        if (rd_en) begin
          ptr_r <= ptr_r + NW'(1);
        end
        if (cmd.walk_scan && rd_vld_r && ovl) begin
          hit_r <= 1'b1;
        end
      end
    end
  end

  // final decision on the request
  always_comb begin
    res_st  = atr_pkg::STS_OK;
    res_idx = '0;
    cnt_nxt = cnt_r;
    append  = 1'b0;
    case (op_r)
      atr_pkg::OP_ALLOC: begin
        if (pre_st != atr_pkg::STS_OK) begin
          res_st = pre_st;
        end else if (hit_r) begin
          res_st = atr_pkg::STS_OVERLAP;
        end else if (cnt_r >= NW'(atr_pkg::MAX_TILES)) begin
          res_st = atr_pkg::STS_FULL;
        end else begin
          append  = cmd.finish;
          res_idx = cnt_r[AW-1:0];
          cnt_nxt = cnt_r + NW'(1);
        end
      end
      atr_pkg::OP_FREE: begin
        if (!idx_ok) begin
          res_st = atr_pkg::STS_BADINDEX;
        end else begin
          cnt_nxt = cnt_r - NW'(1);
        end
      end
      atr_pkg::OP_CLEAR: begin
        cnt_nxt = '0;
      end
      default: begin
        cnt_nxt = cnt_r;
      end
    endcase
  end

  // table write port: append on finish, move down during compaction
  always_comb begin
    wr_en   = append || (cmd.walk_shift && rd_vld_r);
    wr_addr = append ? cnt_r[AW-1:0] : rd_addr_r - AW'(1);
    wr_data = append ? atr_pkg::entry_t'{left_r, top_r, wid_r, hgt_r} : rd_data_r;
  end

  // tile table memory
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[ptr_r[AW-1:0]];
      rd_addr_r <= ptr_r[AW-1:0];
    end
  end

  // tile count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (cmd.finish) begin
      cnt_r <= cnt_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (cmd.finish) begin
      out_vld_r <= 1'b1;
    end else if (out_tready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      res_st_r  <= res_st;
      res_idx_r <= res_idx;
      res_cnt_r <= cnt_nxt;
    end
  end

  // status back to the controller
  always_comb begin
    sts.go_scan   = (op_r == atr_pkg::OP_ALLOC) && (pre_st == atr_pkg::STS_OK);
    sts.go_shift  = (op_r == atr_pkg::OP_FREE) && idx_ok;
    sts.walk_done = !(ptr_r < cnt_r) && !rd_vld_r;
    sts.out_free  = !out_vld_r || out_tready;
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {res_cnt_r, res_idx_r, res_st_r};

  // count stays within the table
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= NW'(atr_pkg::MAX_TILES))
    else $error("tile count beyond table depth");

  // count moves only when a request finishes
  a_cnt_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !cmd.finish |=> $stable(cnt_r))
    else $error("tile count changed outside finish");

  // read data is valid only the cycle after a read
  a_rd_vld: assert property (@(posedge clk) disable iff (!rst_n)
    rd_vld_r && !$past(cmd.walk_init) |-> $past(rd_en))
    else $error("read data flagged without a read");

endmodule
`default_nettype wire

// ===== hw/rtl/atlas_rect_tile_allocator.sv =====
// sequence: an allocate that passes the size, alignment and bounds checks walks the
//   table with one read per stored tile; a free moves each entry after the freed one
//   down by one place; every other item goes from evaluation straight to its result
// throughput: one item at a time, next item accepted the cycle after the result is
//   registered; a new result waits while the previous one has not been taken
// reset: synchronous active-low rst_n empties the table, restores 1024x1024 unaligned
`default_nettype none
module atlas_rect_tile_allocator (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  // op, rect_left, rect_top, rect_width, rect_height, target_index (lowest bit first)
  input  wire logic [63:0]                   in_tdata,
  input  wire logic                          in_tvalid,
  output logic                               in_tready,
  // status, tile_index, tile_count (lowest bit first)
  output logic [15:0]                        out_tdata,
  output logic                               out_tvalid,
  input  wire logic                          out_tready,
  input  wire logic                          cfg_we,
  input  wire logic [atr_pkg::CFG_AW-1:0]    cfg_addr,
  input  wire logic [atr_pkg::CFG_DW-1:0]    cfg_wdata
);

  logic [atr_pkg::SIZE_W-1:0] atlas_w_r, atlas_h_r;
  logic                       blk_align_r;
  atr_pkg::cmd_t              cmd;
  atr_pkg::sts_t              sts;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      atlas_w_r   <= atr_pkg::ATLAS_DIM_RST;
      atlas_h_r   <= atr_pkg::ATLAS_DIM_RST;
      blk_align_r <= 1'b0;
    end else if (cfg_we) begin
      case (atr_pkg::cfg_idx_t'(cfg_addr))
        atr_pkg::CFG_ATLAS_WIDTH:  atlas_w_r   <= cfg_wdata;
        atr_pkg::CFG_ATLAS_HEIGHT: atlas_h_r   <= cfg_wdata;
        atr_pkg::CFG_BLOCK_ALIGN:  blk_align_r <= cfg_wdata[0];
        default: begin
        end
      endcase
    end
  end

  // sequencer
  atr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // table, checks and result register
  atr_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_tdata   (in_tdata),
    .atlas_w    (atlas_w_r),
    .atlas_h    (atlas_h_r),
    .blk_align  (blk_align_r),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule
`default_nettype wire

// ===== bench/tb_top.sv =====
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import atr_pkg::*;

  localparam int CYCLE_LIMIT = 1_200_000;
  localparam int PHASE_ITEMS = 232;

  // one request item, first field in the lowest bits
  typedef struct packed {
    logic [6:0]         idx;
    logic [SIZE_W-1:0]  hgt;
    logic [SIZE_W-1:0]  wid;
    logic [COORD_W-1:0] top;
    logic [COORD_W-1:0] left;
    op_t                op;
  } req_t;

  typedef struct {
    status_t          status;
    logic [IDX_W-1:0] index;
    logic [CNT_W-1:0] count;
  } res_t;

  typedef struct {
    int left;
    int top;
    int wid;
    int hgt;
  } tile_rec_t;

  typedef enum {RX_OPEN, RX_RANDOM, RX_PATTERN} rx_mode_t;

  logic                clk;
  logic                rst_n     = 1'b0;
  // op, rect_left, rect_top, rect_width, rect_height, target_index (lowest bit first)
  logic [63:0]         in_tdata  = '0;
  logic                in_tvalid = 1'b0;
  logic                in_tready;
  // status, tile_index, tile_count (lowest bit first)
  logic [15:0]         out_tdata;
  logic                out_tvalid;
  logic                out_tready = 1'b0;
  logic                cfg_we    = 1'b0;
  logic [CFG_AW-1:0]   cfg_addr  = CFG_ATLAS_WIDTH;
  logic [CFG_DW-1:0]   cfg_wdata = '0;

  // shadow of the allocator state
  tile_rec_t tile_tab [MAX_TILES];
  int        tile_cnt = 0;
  int        atlas_w  = 1024;
  int        atlas_h  = 1024;
  bit        align_on = 1'b0;

  res_t pending_results [$];
  res_t chk_exp;
  int   err_cnt   = 0;
  int   cycle_cnt = 0;

  // sender burst state
  int burst_left = 0;

  // receiver stall state
  int       hold_req  = 0;
  int       hold_left = 0;
  rx_mode_t rx_mode   = RX_OPEN;
  int       rx_left   = 0;
  int       rx_period = 2;
  int       rx_phase  = 0;

  atlas_rect_tile_allocator dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  // clock
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // run-away guard
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // works out the answer to one request and updates the shadow table
  function automatic res_t predict_tile_result(input req_t r);
    res_t e;
    int   il, it, rgt, bot, i;
    bit   hit;
    e.status = STS_OK;
    e.index  = '0;
    hit      = 1'b0;
    il  = int'(r.left);
    it  = int'(r.top);
    rgt = il + int'(r.wid);
    bot = it + int'(r.hgt);
    case (r.op)
      OP_ALLOC: begin
        if (r.wid == 0 || r.hgt == 0) begin
          e.status = STS_EMPTY;
        end else if (align_on &&
                     ((r.left[1:0] | r.top[1:0] | r.wid[1:0] | r.hgt[1:0]) & ALIGN_MASK)
                     != 2'b00) begin
          e.status = STS_MISALIGN;
        end else if (rgt > atlas_w || bot > atlas_h) begin
          e.status = STS_BOUNDS;
        end else begin
          for (i = 0; i < tile_cnt; i++) begin
            if (!(tile_tab[i].left >= rgt || tile_tab[i].left + tile_tab[i].wid <= il ||
                  tile_tab[i].top >= bot || tile_tab[i].top + tile_tab[i].hgt <= it))
              hit = 1'b1;
          end
          if (hit) begin
            e.status = STS_OVERLAP;
          end else if (tile_cnt >= MAX_TILES) begin
            e.status = STS_FULL;
          end else begin
            tile_tab[tile_cnt] = '{il, it, int'(r.wid), int'(r.hgt)};
            e.index = IDX_W'(tile_cnt);
            tile_cnt++;
          end
        end
      end
      OP_FREE: begin
        if (int'(r.idx) >= tile_cnt) begin
          e.status = STS_BADINDEX;
        end else begin
          for (i = int'(r.idx); i + 1 < tile_cnt; i++)
            tile_tab[i] = tile_tab[i + 1];
          tile_cnt--;
        end
      end
      OP_CLEAR: tile_cnt = 0;
      default: ;
    endcase
    e.count = CNT_W'(tile_cnt);
    return e;
  endfunction

  function automatic req_t mk_req(input op_t op, input int l, input int t, input int w,
                                  input int h, input int idx);
    req_t r;
    r.op   = op;
    r.left = COORD_W'(l);
    r.top  = COORD_W'(t);
    r.wid  = SIZE_W'(w);
    r.hgt  = SIZE_W'(h);
    r.idx  = 7'(idx);
    return r;
  endfunction

  // mostly well-formed traffic: grid cells, tiles touching stored ones, plus noise
  function automatic req_t random_request(input int alloc_pct, input int free_pct);
    req_t r;
    int   sel, cw, ch, cx, cy, l, t, w, h, k, n;
    sel = $urandom_range(0, 99);
    r = mk_req(OP_ALLOC, $urandom_range(0, 8191), $urandom_range(0, 8191),
               $urandom_range(0, 16383), $urandom_range(0, 16383), $urandom_range(0, 127));
    if (sel < alloc_pct) begin
      cw = atlas_w / 8;
      ch = atlas_h / 8;
      if (align_on) begin
        cw = cw & ~3;
        ch = ch & ~3;
      end
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: if (cw >= 4 && ch >= 4) begin
          cx = $urandom_range(0, 7) * cw;
          cy = $urandom_range(0, 7) * ch;
          if (align_on) begin
            l = cx;
            t = cy;
            w = 4 * $urandom_range(1, cw / 4);
            h = 4 * $urandom_range(1, ch / 4);
          end else begin
            l = cx + $urandom_range(0, cw - 1);
            t = cy + $urandom_range(0, ch - 1);
            w = $urandom_range(1, cx + cw - l);
            h = $urandom_range(1, cy + ch - t);
          end
          r = mk_req(OP_ALLOC, l, t, w, h, r.idx);
        end
        6, 7: if (tile_cnt > 0) begin
          // edge against a stored tile, either just touching or one step in
          n = $urandom_range(0, tile_cnt - 1);
          k = align_on ? 4 * $urandom_range(0, 1) : $urandom_range(0, 1);
          w = align_on ? 4 * $urandom_range(1, 2) : $urandom_range(1, 8);
          h = align_on ? 4 * $urandom_range(1, 2) : $urandom_range(1, 8);
          l = tile_tab[n].left;
          t = tile_tab[n].top;
          case ($urandom_range(0, 3))
            0:       l = l + tile_tab[n].wid - k;
            1:       l = l - w + k;
            2:       t = t + tile_tab[n].hgt - k;
            default: t = t - h + k;
          endcase
          r = mk_req(OP_ALLOC, l, t, w, h, r.idx);
        end
        8: ;
        default: begin
          r = mk_req(OP_ALLOC, $urandom_range(0, atlas_w), $urandom_range(0, atlas_h),
                     $urandom_range(0, 32), $urandom_range(0, 32), r.idx);
        end
      endcase
    end else if (sel < alloc_pct + free_pct) begin
      r.op = OP_FREE;
      if (tile_cnt > 0 && $urandom_range(0, 99) < 85)
        r.idx = 7'($urandom_range(0, tile_cnt - 1));
    end else if (sel < alloc_pct + free_pct + 1) begin
      r.op = OP_CLEAR;
    end else if (sel < alloc_pct + free_pct + 3) begin
      r.op = OP_NOP;
    end
    return r;
  endfunction

  // offers one item, in bursts with gaps, and records its answer once taken
  task automatic send_item(input req_t r);
    int gap;
    @(negedge clk);
    gap = 0;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      if ($urandom_range(0, 3) != 0)
        gap = $urandom_range(1, 12);
    end
    burst_left--;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tdata  <= {1'b0, r};
    in_tvalid <= 1'b1;
    do begin
      @(posedge clk);
    end while (!in_tready);
    pending_results.insert(pending_results.size(), predict_tile_result(r));
  endtask

  task automatic wait_idle(input int settle);
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (settle) @(negedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t a, input int v);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= a;
    cfg_wdata <= CFG_DW'(v);
    case (a)
      CFG_ATLAS_WIDTH:  atlas_w  = v & 'h3FFF;
      CFG_ATLAS_HEIGHT: atlas_h  = v & 'h3FFF;
      CFG_BLOCK_ALIGN:  align_on = v[0];
      default: ;
    endcase
  endtask

  task automatic close_cfg;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_atlas(input int w, input int h, input bit al);
    wait_idle(8);
    write_reg(CFG_ATLAS_WIDTH, w);
    write_reg(CFG_ATLAS_HEIGHT, h);
    write_reg(CFG_BLOCK_ALIGN, al);
    close_cfg;
  endtask

  // default 1024x1024 unaligned atlas straight out of reset
  task automatic test_reset_state;
    send_item(mk_req(OP_NOP, 8191, 8191, 16383, 16383, 127));
    send_item(mk_req(OP_FREE, 0, 0, 0, 0, 0));
    send_item(mk_req(OP_ALLOC, 0, 0, 0, 5, 0));
    send_item(mk_req(OP_ALLOC, 0, 0, 5, 0, 0));
    send_item(mk_req(OP_ALLOC, 1, 0, 1024, 1, 0));
    send_item(mk_req(OP_ALLOC, 0, 0, 1024, 1024, 0));
    send_item(mk_req(OP_ALLOC, 8191, 8191, 16383, 16383, 0));
    send_item(mk_req(OP_ALLOC, 0, 0, 1, 1, 0));
    send_item(mk_req(OP_FREE, 0, 0, 0, 0, 1));
    send_item(mk_req(OP_FREE, 0, 0, 0, 0, 127));
    send_item(mk_req(OP_FREE, 0, 0, 0, 0, 0));
    send_item(mk_req(OP_ALLOC, 0, 0, 16, 16, 0));
    send_item(mk_req(OP_ALLOC, 16, 0, 16, 16, 0));
    send_item(mk_req(OP_ALLOC, 15, 16, 1, 1, 0));
    send_item(mk_req(OP_ALLOC, 15, 15, 1, 1, 0));
    send_item(mk_req(OP_CLEAR, 0, 0, 0, 0, 0));
    send_item(mk_req(OP_CLEAR, 0, 0, 0, 0, 0));
  endtask

  // block-aligned mode, incl. check precedence around it
  task automatic test_alignment;
    set_atlas(1024, 1024, 1'b1);
    send_item(mk_req(OP_ALLOC, 1, 0, 0, 4, 0));
    send_item(mk_req(OP_ALLOC, 1, 0, 4, 4, 0));
    send_item(mk_req(OP_ALLOC, 0, 2, 4, 4, 0));
    send_item(mk_req(OP_ALLOC, 0, 0, 6, 4, 0));
    send_item(mk_req(OP_ALLOC, 0, 0, 4, 3, 0));
    send_item(mk_req(OP_ALLOC, 1, 0, 2000, 4, 0));
    send_item(mk_req(OP_ALLOC, 4, 4, 8, 8, 0));
    send_item(mk_req(OP_ALLOC, 1020, 1020, 8, 4, 0));
  endtask

  // zero, one-pixel, largest and out-of-range atlas sizes
  task automatic test_atlas_extremes;
    set_atlas(0, 1024, 1'b0);
    send_item(mk_req(OP_CLEAR, 0, 0, 0, 0, 0));
    send_item(mk_req(OP_ALLOC, 0, 0, 1, 1, 0));
    send_item(mk_req(OP_ALLOC, 0, 0, 0, 1, 0));
    set_atlas(1, 1, 1'b0);
    send_item(mk_req(OP_ALLOC, 0, 0, 1, 1, 0));
    send_item(mk_req(OP_ALLOC, 0, 1, 1, 1, 0));
    set_atlas(8192, 8192, 1'b1);
    send_item(mk_req(OP_CLEAR, 0, 0, 0, 0, 0));
    send_item(mk_req(OP_ALLOC, 0, 0, 8192, 8192, 0));
    send_item(mk_req(OP_ALLOC, 8188, 8188, 4, 4, 0));
    set_atlas(16383, 16383, 1'b0);
    send_item(mk_req(OP_ALLOC, 8191, 8191, 8192, 8192, 0));
    wait_idle(8);
    write_reg(CFG_UNUSED, 'h3FFF);
    close_cfg;
    send_item(mk_req(OP_ALLOC, 8191, 0, 8192, 1, 0));
    send_item(mk_req(OP_CLEAR, 0, 0, 0, 0, 0));
  endtask

  // one tile per 128x128 cell until the table is full, then frees around the ends
  task automatic test_fill_to_capacity;
    int cx, cy;
    set_atlas(1024, 1024, 1'b0);
    send_item(mk_req(OP_CLEAR, 0, 0, 0, 0, 0));
    for (cy = 0; cy < 8; cy++) begin
      for (cx = 0; cx < 8; cx++) begin
        send_item(mk_req(OP_ALLOC, cx * 128 + $urandom_range(0, 20),
                         cy * 128 + $urandom_range(0, 20),
                         $urandom_range(1, 100), $urandom_range(1, 100), 0));
      end
    end
    // overlap wins over a full table
    send_item(mk_req(OP_ALLOC, tile_tab[0].left, tile_tab[0].top, 1, 1, 0));
    send_item(mk_req(OP_ALLOC, 1020, 1020, 4, 4, 0));
    send_item(mk_req(OP_FREE, 0, 0, 0, 0, 64));
    send_item(mk_req(OP_FREE, 0, 0, 0, 0, 63));
    send_item(mk_req(OP_FREE, 0, 0, 0, 0, 0));
    send_item(mk_req(OP_FREE, 0, 0, 0, 0, 62));
    send_item(mk_req(OP_ALLOC, 1020, 1020, 4, 4, 0));
    send_item(mk_req(OP_ALLOC, 1016, 1016, 4, 4, 0));
    send_item(mk_req(OP_ALLOC, 1010, 1010, 4, 4, 0));
  endtask

  // result side held off for a long stretch while requests keep coming
  task automatic test_output_hold;
    int n;
    wait_idle(8);
    hold_req = 400;
    for (n = 0; n < 16; n++)
      send_item(random_request(60, 30));
  endtask

  task automatic test_random_traffic;
    int ph, n, a_pct, f_pct;
    for (ph = 0; ph < 7; ph++) begin
      case (ph)
        0:       set_atlas(1024, 1024, 1'b0);
        1:       set_atlas(1024, 1024, 1'b1);
        2:       set_atlas(8192, 8192, 1'b0);
        3:       set_atlas(64, 48, 1'b0);
        4:       set_atlas(256, 512, 1'b1);
        default: set_atlas($urandom_range(1, 8192), $urandom_range(1, 8192),
                           $urandom_range(0, 1));
      endcase
      a_pct = $urandom_range(45, 70);
      f_pct = $urandom_range(10, 25);
      for (n = 0; n < PHASE_ITEMS; n++)
        send_item(random_request(a_pct, f_pct));
    end
  endtask

  // result side: long hold-off on request, otherwise shifting stall patterns
  always @(negedge clk) begin
    if (hold_req > 0) begin
      hold_left = hold_req;
      hold_req  = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      if (rx_left == 0) begin
        rx_mode   = rx_mode_t'($urandom_range(0, 2));
        rx_left   = $urandom_range(20, 300);
        rx_period = $urandom_range(2, 16);
      end
      rx_left--;
      rx_phase++;
      case (rx_mode)
        RX_OPEN:   out_tready <= 1'b1;
        RX_RANDOM: out_tready <= ($urandom_range(0, 99) < 60);
        default:   out_tready <= ((rx_phase % rx_period) <= rx_period / 2);
      endcase
    end
  end

  // compare each result item with the oldest pending answer
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        $error("result item with nothing pending: %h", out_tdata);
        err_cnt++;
      end else begin
        chk_exp = pending_results.pop_front();
        if (out_tdata[2:0] !== chk_exp.status) begin
          $error("status: expected %0d actual %0d", chk_exp.status, out_tdata[2:0]);
          err_cnt++;
        end
        if (out_tdata[8:3] !== chk_exp.index) begin
          $error("tile_index: expected %0d actual %0d", chk_exp.index, out_tdata[8:3]);
          err_cnt++;
        end
        if (out_tdata[15:9] !== chk_exp.count) begin
          $error("tile_count: expected %0d actual %0d", chk_exp.count, out_tdata[15:9]);
          err_cnt++;
        end
      end
    end
  end

  initial begin
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    test_reset_state;
    test_alignment;
    test_atlas_extremes;
    test_fill_to_capacity;
    test_output_hold;
    test_random_traffic;
    wait_idle(80);
    if (err_cnt == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/atr_pkg.sv
hw/rtl/atr_ctrl.sv
hw/rtl/atr_dp.sv
hw/rtl/atlas_rect_tile_allocator.sv
bench/tb_top.sv
